// ===== rtl/core/vbs_pkg.sv =====
// shared constants, codes and types of the validated bounded stack
`default_nettype none

package vbs_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int CFG_IDX_W   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER   = 2'd3;

  // filter modes
  localparam logic [1:0] FILTER_NONE  = 2'd0;
  localparam logic [1:0] FILTER_EVEN  = 2'd1;
  localparam logic [1:0] FILTER_PRIME = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_REJECT    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_UNDERFLOW = 2'd3;

  // operations
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // configuration reset values
  localparam logic signed [DATA_W-1:0] RESET_LOWER = 32'sd1;
  localparam logic signed [DATA_W-1:0] RESET_UPPER = 32'sd1440;

  // prime checker result
  typedef struct packed {
    logic done;
    logic pass;
  } prime_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/validated_bounded_stack.sv =====
// top level of the bounded lifo stack with push admission filter
//
// input channel (in_valid/in_ready, op, value): one transfer per operation,
// op 0 pushes value, op 1 pops the top entry. in_ready is high only while
// no operation is in progress; one operation is handled at a time.
// output channel (out_valid/out_ready, status, data_out, occupancy): one
// result transfer per operation, in order. the result sits in an output
// register, so the next operation may be taken while it waits.
// overflow, underflow, reject and plain push set a pending result (S_DONE),
// which then moves to the output register; a pop first passes S_READ for the
// registered memory read, and a prime push waits in S_PRIME for the verdict.
// a new transfer is taken only once the last result has moved on. prime mode
// tries divisors 2, 3, then odd ones up to the square root; each trial runs
// the 31 magnitude bits through the remainder unit, one bit a cycle, so that
// remainder unit sets the worst-case rate.
// if the receiver stalls, the finished result is held in the output
// register and the next result waits in the block; in_ready stays low.
// reset (rst, synchronous) empties the stack and restores the config registers
// to enable 1, bounds 1..1440, filter none. entries need no clear. config writes
// (cfg_write, cfg_index, cfg_data) take effect at once; the user must make them
// only while the block is idle, as the block itself does not enforce it.
`default_nettype none

module validated_bounded_stack
  import vbs_pkg::*;
#(
  parameter int DEPTH = STACK_DEPTH,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int COUNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // configuration
  input  wire logic                     cfg_write,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [DATA_W-1:0]        cfg_data,
  // operations
  input  wire logic                     in_valid,
  output      logic                     in_ready,
  input  wire logic                     op,
  input  wire logic signed [DATA_W-1:0] value,
  // results
  output      logic                     out_valid,
  input  wire logic                     out_ready,
  output      logic [1:0]               status,
  output      logic signed [DATA_W-1:0] data_out,
  output      logic [COUNT_W-1:0]       occupancy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PRIME = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  // configuration registers
  logic                     range_en;
  logic signed [DATA_W-1:0] lower_bound;
  logic signed [DATA_W-1:0] upper_bound;
  logic [1:0]               filter_mode;

  // control and pending result
  logic [1:0]               state;
  logic [COUNT_W-1:0]       count;
  logic [DATA_W-1:0]        push_value;
  logic [1:0]               pend_status;
  logic [DATA_W-1:0]        pend_data;

  logic                     in_fire;
  logic                     load_out;
  logic                     full;
  logic                     empty;
  logic                     out_of_range;
  logic [COUNT_W-1:0]       count_dec;
  logic                     mem_we;
  logic [DATA_W-1:0]        mem_wdata;
  logic                     mem_re;
  logic [DATA_W-1:0]        mem_rdata;
  logic                     prime_start;
  prime_res_t               prime_res;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    in_fire      = in_valid && in_ready;
    // pending result moves to the output register once that register frees
    load_out     = (state == S_DONE) && (!out_valid || out_ready);
    full         = (count == COUNT_W'(DEPTH));
    empty        = (count == '0);
    count_dec    = count - 1'b1;
    out_of_range = (value < lower_bound) || (value > upper_bound);
    mem_we       = 1'b0;
    mem_wdata    = value;
    mem_re       = 1'b0;
    prime_start  = 1'b0;

    if (state == S_IDLE && in_fire) begin
      if (op == OP_PUSH) begin
        if (!full) begin
          if (!range_en) begin
            mem_we = 1'b1;
          end else if (!out_of_range) begin
            case (filter_mode)
              FILTER_EVEN:  mem_we = !value[0];
              FILTER_PRIME: prime_start = 1'b1;
              default:      mem_we = 1'b1;   // none, and the unused code
            endcase
          end
        end
      end else begin
        mem_re = !empty;
      end
    end

    // prime verdict arrives later; write from the held push value
    if (state == S_PRIME && prime_res.done && prime_res.pass) begin
      mem_we    = 1'b1;
      mem_wdata = push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      out_valid   <= 1'b0;
      range_en    <= 1'b1;
      lower_bound <= RESET_LOWER;
      upper_bound <= RESET_UPPER;
      filter_mode <= FILTER_NONE;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_RANGE_EN: range_en    <= cfg_data[0];
          REG_LOWER:    lower_bound <= cfg_data;
          REG_UPPER:    upper_bound <= cfg_data;
          REG_FILTER:   filter_mode <= cfg_data[1:0];
          default:      ;
        endcase
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            pend_data <= '0;
            if (op == OP_PUSH) begin
              if (full) begin
                pend_status <= ST_OVERFLOW;
                state       <= S_DONE;
              end else if (prime_start) begin
                push_value <= value;
                state      <= S_PRIME;
              end else if (mem_we) begin
                count       <= count + 1'b1;
                pend_status <= ST_OK;
                state       <= S_DONE;
              end else begin
                pend_status <= ST_REJECT;
                state       <= S_DONE;
              end
            end else begin
              if (empty) begin
                pend_status <= ST_UNDERFLOW;
                state       <= S_DONE;
              end else begin
                count       <= count_dec;
                pend_status <= ST_OK;
                state       <= S_READ;
              end
            end
          end
        end
        S_PRIME: begin
          if (prime_res.done) begin
            if (prime_res.pass) begin
              count       <= count + 1'b1;
              pend_status <= ST_OK;
            end else begin
              pend_status <= ST_REJECT;
            end
            state <= S_DONE;
          end
        end
        S_READ: begin
          // read data registered by the memory in the cycle after the address
          pend_data <= mem_rdata;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            status    <= pend_status;
            data_out  <= pend_data;
            occupancy <= count;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  vbs_stack_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (count_dec[ADDR_W-1:0]),
    .rdata (mem_rdata)
  );

  vbs_prime_check u_prime (
    .clk   (clk),
    .rst   (rst),
    .start (prime_start),
    .value (value),
    .res   (prime_res)
  );

  // fill level never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(DEPTH))
    else $error("stack count above depth");

  // no store write into a full stack
  a_write_not_full: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !full)
    else $error("store write while full");

  // a pop of a non-empty stack goes through the memory read
  a_pop_reads: assert property (@(posedge clk) disable iff (rst)
    (in_fire && op == OP_POP && !empty) |=> (state == S_READ))
    else $error("pop did not issue a read");

  // the prime unit only answers while a push waits on it
  a_prime_owner: assert property (@(posedge clk) disable iff (rst)
    prime_res.done |-> (state == S_PRIME))
    else $error("prime verdict with no push waiting");

  // an overflow result always shows a full stack
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OVERFLOW) |-> (occupancy == COUNT_W'(DEPTH)))
    else $error("overflow reported below full");

endmodule

`default_nettype wire

// ===== rtl/core/vbs_stack_mem.sv =====
// stack storage: one write port, one read port, registered read data
`default_nettype none

module vbs_stack_mem
  import vbs_pkg::*;
#(
  parameter int DEPTH = STACK_DEPTH,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vbs_prime_check.sv =====
// trial-division primality filter with a bit-serial remainder unit
`default_nettype none

module vbs_prime_check
  import vbs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic signed [DATA_W-1:0] value,
  output      prime_res_t               res
);

  localparam int U_W   = DATA_W - 1;   // magnitude bits of a positive value
  localparam int N_W   = 16;           // trial divisor, at most 46341
  localparam int SQ_W  = 32;           // divisor squared
  localparam int STEP_W = $clog2(U_W);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_TEST = 2'd1;
  localparam logic [1:0] P_DIV  = 2'd2;

  logic [1:0]        state;
  logic [U_W-1:0]    u;
  logic [U_W-1:0]    dq;
  logic [N_W-1:0]    n;
  logic [SQ_W-1:0]   sq;
  logic [N_W-1:0]    rem;
  logic [STEP_W-1:0] step;

  logic [N_W:0]   trial;
  logic [N_W-1:0] rem_next;

  always_comb begin
    trial = {rem, dq[U_W-1]};
    if (trial >= {1'b0, n}) begin
      rem_next = N_W'(trial - {1'b0, n});
    end else begin
      rem_next = trial[N_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= P_IDLE;
      res.done <= 1'b0;
      res.pass <= 1'b0;
    end else begin
      res.done <= 1'b0;
      case (state)
        P_IDLE: begin
          if (start) begin
            u  <= value[U_W-1:0];
            n  <= N_W'(2);
            sq <= SQ_W'(4);
            // below four no divisor is tried: negatives, 0..3 pass
            if (value < 32'sd4) begin
              res.done <= 1'b1;
              res.pass <= 1'b1;
            end else begin
              state <= P_TEST;
            end
          end
        end
        P_TEST: begin
          if (sq > {1'b0, u}) begin
            res.done <= 1'b1;
            res.pass <= 1'b1;
            state    <= P_IDLE;
          end else begin
            rem   <= '0;
            dq    <= u;
            step  <= '0;
            state <= P_DIV;
          end
        end
        P_DIV: begin
          rem  <= rem_next;
          dq   <= {dq[U_W-2:0], 1'b0};
          step <= step + 1'b1;
          if (step == STEP_W'(U_W - 1)) begin
            if (rem_next == '0) begin
              res.done <= 1'b1;
              res.pass <= 1'b0;
              state    <= P_IDLE;
            end else begin
              // 2, 3, then odd divisors only
              if (n == N_W'(2)) begin
                n  <= N_W'(3);
                sq <= SQ_W'(9);
              end else begin
                n  <= n + N_W'(2);
                sq <= sq + {{(SQ_W-N_W-2){1'b0}}, n, 2'b00} + SQ_W'(4);
              end
              state <= P_TEST;
            end
          end
        end
        default: begin
          state <= P_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for the validated bounded stack
module testbench;
  import vbs_pkg::*;

  // filter mode 3 has no package name; the block treats it like no filter
  localparam logic [1:0] FILTER_UNUSED = 2'd3;
  localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
  // most of the run time goes to prime trials
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned ITEMS_PER_PHASE = 15;

  // pacing of the two channels
  typedef enum int {PACE_FULL, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_t;

  // predicts every operation and holds the results still owed by the block
  class stack_scoreboard;
    typedef struct {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] data;
      logic [4:0]               occ;
    } stack_result_t;

    logic signed [DATA_W-1:0] entries [STACK_DEPTH];
    int unsigned              fill_level;
    bit                       range_on;
    logic signed [DATA_W-1:0] lower;
    logic signed [DATA_W-1:0] upper;
    logic [1:0]               mode;
    stack_result_t            owed [$];
    int unsigned errors, results_seen;
    int unsigned stored, filtered, overflows, underflows, pops_ok;

    function new();
      fill_level = 0;
      range_on   = 1'b1;
      lower      = RESET_LOWER;
      upper      = RESET_UPPER;
      mode       = FILTER_NONE;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] d);
      case (idx)
        REG_RANGE_EN: range_on = d[0];
        REG_LOWER:    lower = d;
        REG_UPPER:    upper = d;
        REG_FILTER:   mode = d[1:0];
        default: ;
      endcase
    endfunction

    // trial division; values below 4 try no divisor at all
    function bit no_divisor(longint v);
      longint n;
      for (n = 2; n * n <= v; n++)
        if (v % n == 0) return 1'b0;
      return 1'b1;
    endfunction

    function bit admits(logic signed [DATA_W-1:0] v);
      if (!range_on) return 1'b1;
      if (v < lower || v > upper) return 1'b0;
      if (mode == FILTER_EVEN) return !v[0];
      if (mode == FILTER_PRIME) return no_divisor(longint'(v));
      return 1'b1;
    endfunction

    // called on every input transfer
    function void note_operation(logic opc, logic signed [DATA_W-1:0] v);
      stack_result_t r;
      r.status = ST_OK;
      r.data   = '0;
      if (opc == OP_PUSH) begin
        if (fill_level >= STACK_DEPTH) begin
          r.status = ST_OVERFLOW;
          overflows++;
        end else if (admits(v)) begin
          entries[fill_level] = v;
          fill_level++;
          stored++;
        end else begin
          r.status = ST_REJECT;
          filtered++;
        end
      end else begin
        if (fill_level == 0) begin
          r.status = ST_UNDERFLOW;
          underflows++;
        end else begin
          fill_level--;
          r.data = entries[fill_level];
          pops_ok++;
        end
      end
      r.occ = 5'(fill_level);
      owed.push_back(r);
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // called on every output transfer
    task check_result(logic [1:0] st, logic signed [DATA_W-1:0] d, logic [4:0] occ);
      stack_result_t r;
      results_seen++;
      if (owed.size() == 0) begin
        report($sformatf("result %0d unexpected: status %0d data %0d occupancy %0d",
                         results_seen, st, d, occ));
        return;
      end
      r = owed.pop_front();
      if (st !== r.status)
        report($sformatf("result %0d status %0d, predicted %0d", results_seen, st, r.status));
      if (d !== r.data)
        report($sformatf("result %0d data_out %0d, predicted %0d", results_seen, d, r.data));
      if (occ !== r.occ)
        report($sformatf("result %0d occupancy %0d, predicted %0d", results_seen, occ, r.occ));
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     op = OP_PUSH;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] data_out;
  logic [4:0]               occupancy;

  stack_scoreboard sb;
  pace_t           pace = PACE_FULL;
  int unsigned     cycle_count = 0;
  int unsigned     sent = 0;

  validated_bounded_stack dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .data_out  (data_out),
    .occupancy (occupancy)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // result side: check each transfer, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        sb.check_result(status, data_out, occupancy);
      case (pace)
        PACE_RECEIVER_STALL: out_ready <= ($urandom_range(0, 99) >= 75);
        PACE_BOTH:           out_ready <= ($urandom_range(0, 99) >= 33);
        default:             out_ready <= 1'b1;
      endcase
    end
  end

  // sender gap: each cycle idles with the phase's probability
  function automatic int unsigned pick_gap();
    int unsigned g;
    int unsigned pct;
    g = 0;
    pct = (pace == PACE_SENDER_IDLE) ? 75 : (pace == PACE_BOTH) ? 33 : 0;
    while (g < 60 && $urandom_range(0, 99) < pct) g++;
    return g;
  endfunction

  // one operation transfer; valid stays up when no gap follows
  task automatic push_or_pop(logic opc, logic signed [DATA_W-1:0] v);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= opc;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_operation(opc, v);
    sent++;
  endtask

  task automatic push(logic signed [DATA_W-1:0] v);
    push_or_pop(OP_PUSH, v);
  endtask

  // value is ignored on a pop, so it carries noise
  task automatic pop();
    push_or_pop(OP_POP, $urandom);
  endtask

  // drop valid and wait for every owed result
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  // rewrite all four registers back to back, only while idle
  task automatic set_admission(bit en, logic signed [DATA_W-1:0] lo,
                               logic signed [DATA_W-1:0] hi, logic [1:0] fmode);
    write_reg(REG_RANGE_EN, DATA_W'(en));
    write_reg(REG_LOWER, lo);
    write_reg(REG_UPPER, hi);
    write_reg(REG_FILTER, DATA_W'(fmode));
    cfg_write <= 1'b0;
  endtask

  // mostly values the current window admits, edges included, some noise
  function automatic logic signed [DATA_W-1:0] pick_value();
    longint lo, hi, span, v;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 30 || !sb.range_on || sb.lower > sb.upper) return $urandom;
    lo = longint'(sb.lower);
    hi = longint'(sb.upper);
    if (sel < 40) return sb.lower;
    if (sel < 50) return sb.upper;
    span = hi - lo;
    v = lo + (longint'($urandom) % (span + 1));
    // even window: mostly well-formed even values
    if (sb.mode == FILTER_EVEN && sel < 85) begin
      v[0] = 1'b0;
      if (v < lo) v = v + 2;
    end
    return v[DATA_W-1:0];
  endfunction

  // fill bursts push one past the free space, drain bursts end in underflow, the rest is mixed
  task automatic random_traffic(int unsigned count);
    int unsigned done_items, kind, len, i;
    done_items = 0;
    while (done_items < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        len = STACK_DEPTH - sb.fill_level + 1;
        for (i = 0; i < len; i++) push(pick_value());
      end else if (kind < 30) begin
        len = sb.fill_level + 1;
        for (i = 0; i < len; i++) pop();
      end else begin
        len = $urandom_range(1, 8);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(0, 99) < 55) push(pick_value());
          else pop();
        end
      end
      done_items += len;
    end
  endtask

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results owed", cycle_count, sb.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset window 1..1440, no filter: bounds inclusive, pop on empty
    pop();
    push(32'sd1);
    push(32'sd1440);
    push(32'sd0);
    push(32'sd1441);
    push(VALUE_MIN);
    pop();

    // checking off: anything goes in
    drain();
    set_admission(1'b0, RESET_LOWER, RESET_UPPER, FILTER_NONE);
    push(VALUE_MAX);
    push(VALUE_MIN);
    push(-32'sd1);

    // full window, even filter on negative and large values
    drain();
    set_admission(1'b1, VALUE_MIN, VALUE_MAX, FILTER_EVEN);
    push(-32'sd3);
    push(-32'sd4);
    push(VALUE_MAX - 1);

    // full window, prime filter: small and negative values pass untested
    drain();
    set_admission(1'b1, VALUE_MIN, VALUE_MAX, FILTER_PRIME);
    push(VALUE_MAX - 1);
    push(-32'sd7);
    push(32'sd3);
    push(32'sd4);
    push(32'sd1000003);
    push(32'sd1000001);
    push(32'sd0);

    // unused filter code acts as bounds only
    drain();
    set_admission(1'b1, 32'sd10, 32'sd20, FILTER_UNUSED);
    push(32'sd9);
    push(32'sd21);
    push(32'sd15);

    // inverted window rejects every push
    drain();
    set_admission(1'b1, 32'sd100, 32'sd50, FILTER_NONE);
    push(32'sd75);

    // top up to full, one overflow, then pop back the latest entries
    drain();
    set_admission(1'b0, RESET_LOWER, RESET_UPPER, FILTER_PRIME);
    while (sb.fill_level < STACK_DEPTH) push($urandom);
    push($urandom);
    pop();
    pop();

    // random phases, each with its own pacing and window
    drain();
    pace = PACE_FULL;
    set_admission(1'b1, VALUE_MIN, VALUE_MAX, FILTER_NONE);
    random_traffic(ITEMS_PER_PHASE);

    drain();
    pace = PACE_SENDER_IDLE;
    set_admission(1'b1, -32'sd500, 32'sd500, FILTER_EVEN);
    random_traffic(ITEMS_PER_PHASE);

    // prime window kept small so trial division stays short
    drain();
    pace = PACE_RECEIVER_STALL;
    set_admission(1'b1, -32'sd50, 32'sd70000, FILTER_PRIME);
    random_traffic(ITEMS_PER_PHASE);

    drain();
    pace = PACE_BOTH;
    set_admission(1'b0, 32'sd7, 32'sd3, FILTER_UNUSED);
    random_traffic(ITEMS_PER_PHASE);

    // all owed results in, then watch a little longer for strays
    drain();
    repeat (12) @(posedge clk);

    $display("ran %0d operations over directed cases and four pacing phases", sent);
    $display("stored %0d, filtered %0d, overflow %0d, underflow %0d, pops with data %0d",
             sb.stored, sb.filtered, sb.overflows, sb.underflows, sb.pops_ok);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
